// ===== design/tte_pkg.sv =====
package tte_pkg;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_CANCEL  = 2'd1,
    KIND_EXPIRED = 2'd2,
    KIND_SUMMARY = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_CANCEL,
    ST_SCAN,
    ST_EVAL
  } state_e;

  localparam int unsigned IdW   = 32;
  localparam int unsigned TimeW = 48;
  localparam int unsigned IvlW  = 32;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [TimeW-1:0] deadline;
    logic [IvlW-1:0]  repeat_interval;
    logic [IdW-1:0]   target_id;
    logic [TimeW-1:0] now_time;
  } in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IdW-1:0]   tmr_id;
    logic             ok;
    logic             next_valid;
    logic [TimeW-1:0] next_deadline;
    logic             last;
  } out_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] deadline;
    logic [IvlW-1:0]  interval;
  } slot_t;

endpackage

// ===== design/tte_slot_ram.sv =====
module tte_slot_ram import tte_pkg::*; #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  slot_t            wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output slot_t            rdata_o
);

  slot_t mem [Depth];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/timer_table_expiry_top.sv =====
// Channel   Ports                        Direction  Transfer
// command   start_i, busy_o, item_i      in         start_i high while busy_o low
// result    res_valid_o, res_o           out        one-cycle strobe, always taken
//
// Add: ST_ADD writes the slot after the accept cycle. Cancel: a scan that stops at a hit or the last slot.
// Tick: one full scan per expiring timer, plus a final scan for the summary;
// each pass walks the slot RAM through its single read port, one slot a cycle.
// Reset clears the valid bits and the id counter at once; slot RAM needs no clearing.
// busy_o drops in the cycle that strobes the last result, so the next item
// may be taken at the edge that ends it.
module timer_table_expiry_top import tte_pkg::*; #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  in_t  item_i,
  output logic res_valid_o,
  output out_t res_o
);

  localparam int unsigned IW = $clog2(TIMER_SLOTS);
  localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);
  localparam logic [IW-1:0] LastIdx  = IW'(TIMER_SLOTS - 1);
  localparam logic [CW-1:0] NumSlots = CW'(TIMER_SLOTS);

  state_e                 state_q, state_d;
  in_t                    req_q, req_d;
  logic [TIMER_SLOTS-1:0] valid_q, valid_d;
  logic [TIMER_SLOTS-1:0] due_q, due_d;
  logic [IdW-1:0]         seq_q, seq_d;
  logic [CW-1:0]          issue_q, issue_d;
  logic                   chk_vld_q, chk_vld_d;
  logic [IW-1:0]          chk_idx_q, chk_idx_d;
  logic                   first_q, first_d;
  logic                   best_vld_q, best_vld_d;
  logic [IW-1:0]          best_idx_q, best_idx_d;
  slot_t                  best_q, best_d;
  logic                   nx_vld_q, nx_vld_d;
  logic [TimeW-1:0]       nx_dl_q, nx_dl_d;
  logic                   res_vld_q, res_vld_d;
  out_t                   res_q, res_d;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  slot_t         ram_wdata;
  slot_t         ram_rdata;

  logic          free_found;
  logic [IW-1:0] free_idx;
  logic          issuing;
  logic          cancel_hit;
  logic          cand;
  logic [TimeW:0]   rearm_sum;
  logic [TimeW-1:0] rearm_dl;

  tte_slot_ram #(
    .Depth (TIMER_SLOTS),
    .AddrW (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (issue_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  assign issuing = ((state_q == ST_CANCEL) || (state_q == ST_SCAN)) && (issue_q < NumSlots);
  assign cancel_hit = valid_q[chk_idx_q] && (ram_rdata.id == req_q.target_id);
  assign cand = first_q ? (valid_q[chk_idx_q] && (ram_rdata.deadline < req_q.now_time))
                        : due_q[chk_idx_q];

  // rearm at tick time plus interval, saturate at the top of the time range
  assign rearm_sum = {1'b0, req_q.now_time} + {{(TimeW + 1 - IvlW){1'b0}}, best_q.interval};
  assign rearm_dl  = rearm_sum[TimeW] ? {TimeW{1'b1}} : rearm_sum[TimeW-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (item_i.cmd)
            CMD_ADD:    state_d = ST_ADD;
            CMD_CANCEL: state_d = ST_CANCEL;
            CMD_TICK:   state_d = ST_SCAN;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD: state_d = ST_IDLE;
      ST_CANCEL: begin
        if (chk_vld_q && (cancel_hit || (chk_idx_q == LastIdx))) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (chk_vld_q && (chk_idx_q == LastIdx)) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: state_d = best_vld_q ? ST_SCAN : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_d      = req_q;
    valid_d    = valid_q;
    due_d      = due_q;
    seq_d      = seq_q;
    issue_d    = issue_q;
    chk_vld_d  = 1'b0;
    chk_idx_d  = issue_q[IW-1:0];
    first_d    = first_q;
    best_vld_d = best_vld_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    nx_vld_d   = nx_vld_q;
    nx_dl_d    = nx_dl_q;
    res_vld_d  = 1'b0;
    res_d      = '0;
    ram_we     = 1'b0;
    ram_waddr  = free_idx;
    ram_wdata  = '{id: seq_q, deadline: req_q.deadline, interval: req_q.repeat_interval};

    if (issuing) begin
      chk_vld_d = 1'b1;
      issue_d   = issue_q + 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_d      = item_i;
          issue_d    = '0;
          first_d    = 1'b1;
          best_vld_d = 1'b0;
          nx_vld_d   = 1'b0;
          due_d      = '0;
        end
      end
      ST_ADD: begin
        res_vld_d  = 1'b1;
        res_d.kind = KIND_ADD;
        res_d.last = 1'b1;
        if (free_found) begin
          ram_we            = 1'b1;
          valid_d[free_idx] = 1'b1;
          seq_d             = seq_q + 1'b1;
          res_d.tmr_id      = seq_q;
          res_d.ok          = 1'b1;
        end
      end
      ST_CANCEL: begin
        if (chk_vld_q) begin
          if (cancel_hit) begin
            valid_d[chk_idx_q] = 1'b0;
            res_vld_d      = 1'b1;
            res_d.kind     = KIND_CANCEL;
            res_d.tmr_id   = req_q.target_id;
            res_d.ok       = 1'b1;
            res_d.last     = 1'b1;
          end else if (chk_idx_q == LastIdx) begin
            res_vld_d      = 1'b1;
            res_d.kind     = KIND_CANCEL;
            res_d.tmr_id   = req_q.target_id;
            res_d.last     = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (chk_vld_q) begin
          if (first_q) begin
            due_d[chk_idx_q] = cand;
          end
          // strict compare keeps the lowest slot on equal deadlines
          if (cand && (!best_vld_q || (ram_rdata.deadline < best_q.deadline))) begin
            best_vld_d = 1'b1;
            best_idx_d = chk_idx_q;
            best_d     = ram_rdata;
          end
          if (valid_q[chk_idx_q] && (ram_rdata.deadline > req_q.now_time) &&
              (!nx_vld_q || (ram_rdata.deadline < nx_dl_q))) begin
            nx_vld_d = 1'b1;
            nx_dl_d  = ram_rdata.deadline;
          end
        end
      end
      ST_EVAL: begin
        res_vld_d = 1'b1;
        if (best_vld_q) begin
          res_d.kind     = KIND_EXPIRED;
          res_d.tmr_id   = best_q.id;
          due_d[best_idx_q] = 1'b0;
          if (best_q.interval != '0) begin
            ram_we    = 1'b1;
            ram_waddr = best_idx_q;
            ram_wdata = '{id: best_q.id, deadline: rearm_dl, interval: best_q.interval};
          end else begin
            valid_d[best_idx_q] = 1'b0;
          end
          // start another pass over the remaining due timers
          issue_d    = '0;
          first_d    = 1'b0;
          best_vld_d = 1'b0;
          nx_vld_d   = 1'b0;
        end else begin
          res_d.kind          = KIND_SUMMARY;
          res_d.next_valid    = nx_vld_q;
          res_d.next_deadline = nx_vld_q ? nx_dl_q : '0;
          res_d.last          = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      valid_q    <= '0;
      due_q      <= '0;
      seq_q      <= '0;
      issue_q    <= '0;
      chk_vld_q  <= 1'b0;
      first_q    <= 1'b0;
      best_vld_q <= 1'b0;
      nx_vld_q   <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      due_q      <= due_d;
      seq_q      <= seq_d;
      issue_q    <= issue_d;
      chk_vld_q  <= chk_vld_d;
      first_q    <= first_d;
      best_vld_q <= best_vld_d;
      nx_vld_q   <= nx_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    chk_idx_q  <= chk_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    nx_dl_q    <= nx_dl_d;
    res_q      <= res_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

// ===== design/tte_checker.sv =====
module tte_checker import tte_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input in_t  item_i,
  input logic res_valid_o,
  input out_t res_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (item_i.cmd != CMD_NONE) |=> busy_o)
    else $error("item accepted but block not busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy_o))
    else $error("result without an item in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |-> !busy_o)
    else $error("still busy after last result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy_o)
    else $error("idle before last result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind == KIND_SUMMARY) |-> res_o.last)
    else $error("tick summary not marked last");

endmodule

bind timer_table_expiry_top tte_checker u_tte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .item_i      (item_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

// ===== bench/timer_table_checker.sv =====
`timescale 1ns / 100ps

module timer_table_checker import tte_pkg::*; #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  in_t  item_i,
  input  logic res_valid_i,
  input  out_t res_i,
  output int   errors_o,
  output int   outstanding_o,
  output int   replies_o
);

  localparam logic [TimeW-1:0] TimeMax = '1;
  localparam int               MaxReports = 10;

  logic           live_q  [TIMER_SLOTS];
  slot_t          slots_q [TIMER_SLOTS];
  logic [IdW-1:0] seq_q;
  out_t           expected_replies [$];
  out_t           want;
  int             errors;
  int             replies;

  function automatic out_t reply(kind_e k, logic [IdW-1:0] id, logic ok, logic nv,
                                 logic [TimeW-1:0] nd, logic last);
    out_t r;
    r.kind          = k;
    r.tmr_id        = id;
    r.ok            = ok;
    r.next_valid    = nv;
    r.next_deadline = nd;
    r.last          = last;
    return r;
  endfunction

  // Apply one command to the timer table and queue the replies it causes.
  function automatic void run_command(in_t it);
    logic             due [TIMER_SLOTS];
    logic             found;
    logic             nv;
    logic [TimeW-1:0] nd;
    logic [TimeW:0]   rearm;
    int               best;
    case (cmd_e'(it.cmd))
      CMD_ADD: begin
        found = 1'b0;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (!found && !live_q[i]) begin
            found                = 1'b1;
            live_q[i]            = 1'b1;
            slots_q[i].id        = seq_q;
            slots_q[i].deadline  = it.deadline;
            slots_q[i].interval  = it.repeat_interval;
            expected_replies.push_back(reply(KIND_ADD, seq_q, 1'b1, 1'b0, '0, 1'b1));
            seq_q                = seq_q + 1'b1;
          end
        end
        if (!found) begin
          expected_replies.push_back(reply(KIND_ADD, '0, 1'b0, 1'b0, '0, 1'b1));
        end
      end
      CMD_CANCEL: begin
        found = 1'b0;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (!found && live_q[i] && slots_q[i].id == it.target_id) begin
            found     = 1'b1;
            live_q[i] = 1'b0;
          end
        end
        expected_replies.push_back(reply(KIND_CANCEL, it.target_id, found, 1'b0, '0, 1'b1));
      end
      CMD_TICK: begin
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          due[i] = live_q[i] && (slots_q[i].deadline < it.now_time);
        end
        // report due timers earliest first, ties in slot order
        do begin
          best = -1;
          for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (due[i] && (best < 0 || slots_q[i].deadline < slots_q[best].deadline)) begin
              best = i;
            end
          end
          if (best >= 0) begin
            due[best] = 1'b0;
            expected_replies.push_back(reply(KIND_EXPIRED, slots_q[best].id, 1'b0, 1'b0, '0,
                                             1'b0));
            if (slots_q[best].interval != '0) begin
              rearm = {1'b0, it.now_time} + {{(TimeW + 1 - IvlW){1'b0}}, slots_q[best].interval};
              slots_q[best].deadline = rearm[TimeW] ? TimeMax : rearm[TimeW-1:0];
            end else begin
              live_q[best] = 1'b0;
            end
          end
        end while (best >= 0);
        nv = 1'b0;
        nd = '0;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (live_q[i] && slots_q[i].deadline > it.now_time &&
              (!nv || slots_q[i].deadline < nd)) begin
            nv = 1'b1;
            nd = slots_q[i].deadline;
          end
        end
        expected_replies.push_back(reply(KIND_SUMMARY, '0, 1'b0, nv, nd, 1'b1));
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        live_q[i] = 1'b0;
      end
      seq_q = '0;
      expected_replies.delete();
      errors  = 0;
      replies = 0;
    end else begin
      if (res_valid_i) begin
        replies++;
        if (expected_replies.size() == 0) begin
          errors++;
          if (errors <= MaxReports) begin
            $display("%0t: unexpected result kind %0d id %0h ok %0b next %0b/%0h last %0b",
                     $realtime, res_i.kind, res_i.tmr_id, res_i.ok, res_i.next_valid,
                     res_i.next_deadline, res_i.last);
          end
        end else begin
          want = expected_replies.pop_front();
          if (res_i.kind !== want.kind || res_i.tmr_id !== want.tmr_id ||
              res_i.ok !== want.ok || res_i.next_valid !== want.next_valid ||
              res_i.next_deadline !== want.next_deadline || res_i.last !== want.last) begin
            errors++;
            if (errors <= MaxReports) begin
              $display({"%0t: result mismatch (expected/actual): kind %0d/%0d id %0h/%0h",
                        " ok %0b/%0b next %0b/%0b at %0h/%0h last %0b/%0b"},
                       $realtime, want.kind, res_i.kind, want.tmr_id, res_i.tmr_id,
                       want.ok, res_i.ok, want.next_valid, res_i.next_valid,
                       want.next_deadline, res_i.next_deadline, want.last, res_i.last);
            end
          end
        end
      end
      if (start_i && !busy_i) begin
        run_command(item_i);
      end
    end
    errors_o      <= errors;
    outstanding_o <= expected_replies.size();
    replies_o     <= replies;
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import tte_pkg::*;

  localparam int unsigned     Slots       = 16;
  localparam int              RandomItems = 230;
  localparam int              QuietLimit  = 2000;
  localparam int              TailCycles  = 2 * (Slots + 2);
  localparam logic [TimeW-1:0] TimeMax    = '1;
  localparam logic [IvlW-1:0]  IvlMax     = '1;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  in_t  item_i;
  logic res_valid_o;
  out_t res_o;

  int errors;
  int outstanding;
  int replies;
  int quiet;
  int adds_sent;
  int cancels_sent;
  int ticks_sent;
  int ignored_sent;

  logic [TimeW-1:0] sim_now;

  timer_table_expiry_top #(
    .TIMER_SLOTS(Slots)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .item_i     (item_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  timer_table_checker #(
    .TIMER_SLOTS(Slots)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .item_i       (item_i),
    .res_valid_i  (res_valid_o),
    .res_i        (res_o),
    .errors_o     (errors),
    .outstanding_o(outstanding),
    .replies_o    (replies)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || res_valid_o) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("Watchdog: no item or result for %0d cycles", QuietLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [TimeW-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TimeW-1:0];
  endfunction

  // Every field random; the caller overrides the ones the command uses.
  function automatic in_t make_item(cmd_e c);
    in_t it;
    it.cmd             = c;
    it.deadline        = rand48();
    it.repeat_interval = $urandom;
    it.target_id       = $urandom;
    it.now_time        = rand48();
    return it;
  endfunction

  // Hold start high until the item is taken.
  task automatic send_item(input in_t it);
    start_i <= 1'b1;
    item_i  <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    case (cmd_e'(it.cmd))
      CMD_ADD:    adds_sent++;
      CMD_CANCEL: cancels_sent++;
      CMD_TICK:   ticks_sent++;
      default:    ignored_sent++;
    endcase
  endtask

  task automatic maybe_pause(input bit allow);
    if (allow && $urandom_range(99) < 12) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 50)) @(posedge clk_i);
    end
  endtask

  task automatic send_add(input logic [TimeW-1:0] dl, input logic [IvlW-1:0] ivl);
    in_t it;
    it                 = make_item(CMD_ADD);
    it.deadline        = dl;
    it.repeat_interval = ivl;
    send_item(it);
    maybe_pause(1'b1);
  endtask

  task automatic send_cancel(input logic [IdW-1:0] id);
    in_t it;
    it           = make_item(CMD_CANCEL);
    it.target_id = id;
    send_item(it);
    maybe_pause(1'b1);
  endtask

  task automatic send_tick(input logic [TimeW-1:0] now);
    in_t it;
    it          = make_item(CMD_TICK);
    it.now_time = now;
    send_item(it);
    maybe_pause(1'b1);
  endtask

  initial begin
    in_t it;
    int  counted;
    int  sel;
    int  span;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    item_i       = '0;
    adds_sent    = 0;
    cancels_sent = 0;
    ticks_sent   = 0;
    ignored_sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, then an unused command
    send_tick('0);
    send_item(make_item(CMD_NONE));
    maybe_pause(1'b1);
    // fill every slot; ids follow slot order from an empty table
    for (int k = 0; k < Slots; k++) begin
      case (k)
        0:       send_add('0, '0);
        1:       send_add(TimeMax, IvlMax);
        2:       send_add(TimeW'(100), IvlMax);
        3:       send_add(TimeW'(100), '0);
        4:       send_add(TimeW'(50), IvlW'(10));
        default: send_add(TimeW'($urandom_range(200)), '0);
      endcase
    end
    send_add(TimeW'(20), '0);
    send_cancel('1);
    send_cancel(IdW'(3));
    // deadline equal to tick time stays pending
    send_tick(TimeW'(100));
    // rearm saturates at the top of the time range
    send_tick(TimeMax);
    send_tick('0);
    // drop the timers parked at the maximum deadline
    send_cancel(IdW'(1));
    send_cancel(IdW'(2));
    send_cancel(IdW'(4));

    sim_now = TimeW'(1000);
    counted = 0;
    while (counted < RandomItems) begin
      sel = $urandom_range(99);
      if (sel < 5) begin
        it = make_item(CMD_NONE);
      end else if (sel < 45) begin
        it = make_item(CMD_ADD);
        if ($urandom_range(19) != 0) begin
          it.deadline = sim_now + TimeW'($urandom_range(120));
        end
        sel = $urandom_range(9);
        if (sel < 5) begin
          it.repeat_interval = '0;
        end else if (sel < 9) begin
          it.repeat_interval = IvlW'($urandom_range(1, 80));
        end
      end else if (sel < 70) begin
        it  = make_item(CMD_CANCEL);
        sel = $urandom_range(99);
        if (adds_sent > 0 && sel < 60) begin
          span         = (adds_sent > 32) ? 32 : adds_sent;
          it.target_id = IdW'(adds_sent - 1 - int'($urandom_range(span - 1)));
        end else if (adds_sent > 0 && sel < 85) begin
          it.target_id = IdW'($urandom_range(adds_sent));
        end
      end else begin
        it = make_item(CMD_TICK);
        if ($urandom_range(39) != 0) begin
          sim_now     = sim_now + TimeW'($urandom_range(60));
          it.now_time = sim_now;
        end
      end
      send_item(it);
      if (cmd_e'(it.cmd) != CMD_NONE) begin
        counted++;
      end
      // keep a stretch of back-to-back items
      maybe_pause(counted < 100 || counted >= 160);
    end
    start_i <= 1'b0;

    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Ran %0d adds, %0d cancels, %0d ticks and %0d unused commands; %0d results seen.",
             adds_sent, cancels_sent, ticks_sent, ignored_sent, replies);
    if (errors == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== timer_table_expiry_top.f =====
design/tte_pkg.sv
design/tte_slot_ram.sv
design/timer_table_expiry_top.sv
design/tte_checker.sv
bench/timer_table_checker.sv
bench/testbench.sv
